### rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants of the position frame parser: parse phases,
// register indexes, field offsets within a frame and the result layout.
// ----------------------------------------------------------------------------
package pfp_pkg;

	// Frame store depth; bytes at positions at or beyond it are not kept.
	localparam int STORE_DEPTH = 128;

	localparam logic [7:0] HDR_BYTE = 8'h55;

	// Byte offsets of the unpacked fields within a frame.
	localparam int OFS_TIME  = 6;
	localparam int OFS_PRX   = 10;
	localparam int OFS_PRY   = 11;
	localparam int OFS_PRZ   = 12;
	localparam int OFS_PX    = 13;
	localparam int OFS_PY    = 16;
	localparam int OFS_PZ    = 19;
	localparam int OFS_VX    = 22;
	localparam int OFS_VY    = 25;
	localparam int OFS_VZ    = 28;
	localparam int OFS_ROLL  = 76;
	localparam int OFS_PITCH = 78;
	localparam int OFS_YAW   = 80;

	// Only the bytes that feed result fields are kept, in two windows.
	localparam int LO_BASE  = OFS_TIME;
	localparam int LO_COUNT = OFS_VZ + 3 - OFS_TIME;
	localparam int HI_BASE  = OFS_ROLL;
	localparam int HI_COUNT = OFS_YAW + 2 - OFS_ROLL;

	// Configuration register indexes.
	localparam logic CFG_FUNCTION_MARK    = 1'b0;
	localparam logic CFG_MAX_FRAME_LENGTH = 1'b1;

	localparam logic [7:0]  FUNCTION_MARK_RESET    = 8'd4;
	localparam logic [15:0] MAX_FRAME_LENGTH_RESET = 16'd4096;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_MARK   = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_LEN_HI = 3'd3,
		PH_BODY   = 3'd4
	} phase_t;

	// Result layout; the last member sits in the lowest bits.
	typedef struct packed {
		logic signed [15:0] yaw_cdeg;
		logic signed [15:0] pitch_cdeg;
		logic signed [15:0] roll_cdeg;
		logic signed [23:0] vel_z;
		logic signed [23:0] vel_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] pos_z;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_x;
		logic [7:0]         precision_max;
		logic [31:0]        remote_time_ms;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

### rtl/pfp_core.sv
// ----------------------------------------------------------------------------
// pfp_core
// Frame state machine, checksum, the stored field bytes and the unpacking of
// a finished frame. One byte is taken per cycle when step is high.
// ----------------------------------------------------------------------------
module pfp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              step,
	input  logic [7:0]        data_byte,
	output logic              good,
	output pfp_pkg::result_t  result
);
	import pfp_pkg::*;

	logic [7:0]  function_mark_q;
	logic [15:0] max_frame_length_q;

	phase_t      phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  len_lo_q, len_lo_d;

	logic [7:0]  lo_q [LO_COUNT];
	logic [7:0]  hi_q [HI_COUNT];
	logic [7:0]  lo_d [LO_COUNT];
	logic [7:0]  hi_d [HI_COUNT];

	logic [15:0] cnt_inc;
	logic [15:0] len_rx;
	logic        wr_en;
	logic [7:0]  pr_a;
	logic [7:0]  pr_max;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_mark_q    <= FUNCTION_MARK_RESET;
			max_frame_length_q <= MAX_FRAME_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FUNCTION_MARK:    function_mark_q <= cfg_data[7:0];
				CFG_MAX_FRAME_LENGTH: max_frame_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cnt_inc = cnt_q + 16'd1;
	assign len_rx  = {data_byte, len_lo_q};

	// Next phase, counters and checksum.
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		sum_d    = sum_q;
		len_lo_d = len_lo_q;
		good     = 1'b0;
		if (step) begin
			case (phase_q)
				PH_MARK: begin
					if (data_byte == function_mark_q) begin
						cnt_d   = cnt_inc;
						sum_d   = sum_q + data_byte;
						phase_d = PH_LEN_LO;
					end else begin
						phase_d = PH_HEADER;
					end
				end
				PH_LEN_LO: begin
					len_lo_d = data_byte;
					cnt_d    = cnt_inc;
					sum_d    = sum_q + data_byte;
					phase_d  = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d = len_rx;
					if (len_rx > max_frame_length_q) begin
						phase_d = PH_HEADER;
					end else begin
						cnt_d   = cnt_inc;
						sum_d   = sum_q + data_byte;
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q) begin
						phase_d = PH_HEADER;
						good    = (data_byte == sum_q);
					end else begin
						sum_d = sum_q + data_byte;
					end
				end
				default: begin
					phase_d = PH_HEADER;
					if (data_byte == HDR_BYTE) begin
						cnt_d   = 16'd1;
						sum_d   = data_byte;
						phase_d = PH_MARK;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			cnt_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			len_lo_q <= '0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			sum_q    <= sum_d;
			len_lo_q <= len_lo_d;
		end
	end

	// Body bytes land in the field windows at their frame position.
	assign wr_en = step && (phase_q == PH_BODY) && (cnt_q < 16'(STORE_DEPTH));

	always_comb begin
		for (int i = 0; i < LO_COUNT; i++) begin
			lo_d[i] = (wr_en && cnt_q == 16'(LO_BASE + i)) ? data_byte : lo_q[i];
		end
		for (int i = 0; i < HI_COUNT; i++) begin
			hi_d[i] = (wr_en && cnt_q == 16'(HI_BASE + i)) ? data_byte : hi_q[i];
		end
	end

	// The store is cleared at reset, since short frames read stale bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LO_COUNT; i++) lo_q[i] <= '0;
			for (int i = 0; i < HI_COUNT; i++) hi_q[i] <= '0;
		end else begin
			for (int i = 0; i < LO_COUNT; i++) lo_q[i] <= lo_d[i];
			for (int i = 0; i < HI_COUNT; i++) hi_q[i] <= hi_d[i];
		end
	end

	// Unpack from the store as it stands after this byte.
	assign pr_a   = (lo_d[OFS_PRY - LO_BASE] > lo_d[OFS_PRX - LO_BASE]) ?
			lo_d[OFS_PRY - LO_BASE] : lo_d[OFS_PRX - LO_BASE];
	assign pr_max = (lo_d[OFS_PRZ - LO_BASE] > pr_a) ? lo_d[OFS_PRZ - LO_BASE] : pr_a;

	always_comb begin
		result.remote_time_ms = {lo_d[OFS_TIME - LO_BASE + 3], lo_d[OFS_TIME - LO_BASE + 2],
			lo_d[OFS_TIME - LO_BASE + 1], lo_d[OFS_TIME - LO_BASE]};
		result.precision_max  = pr_max;
		result.pos_x = {lo_d[OFS_PX - LO_BASE + 2], lo_d[OFS_PX - LO_BASE + 1],
			lo_d[OFS_PX - LO_BASE]};
		result.pos_y = {lo_d[OFS_PY - LO_BASE + 2], lo_d[OFS_PY - LO_BASE + 1],
			lo_d[OFS_PY - LO_BASE]};
		result.pos_z = {lo_d[OFS_PZ - LO_BASE + 2], lo_d[OFS_PZ - LO_BASE + 1],
			lo_d[OFS_PZ - LO_BASE]};
		result.vel_x = {lo_d[OFS_VX - LO_BASE + 2], lo_d[OFS_VX - LO_BASE + 1],
			lo_d[OFS_VX - LO_BASE]};
		result.vel_y = {lo_d[OFS_VY - LO_BASE + 2], lo_d[OFS_VY - LO_BASE + 1],
			lo_d[OFS_VY - LO_BASE]};
		result.vel_z = {lo_d[OFS_VZ - LO_BASE + 2], lo_d[OFS_VZ - LO_BASE + 1],
			lo_d[OFS_VZ - LO_BASE]};
		result.roll_cdeg  = {hi_d[OFS_ROLL - HI_BASE + 1], hi_d[OFS_ROLL - HI_BASE]};
		result.pitch_cdeg = {hi_d[OFS_PITCH - HI_BASE + 1], hi_d[OFS_PITCH - HI_BASE]};
		result.yaw_cdeg   = {hi_d[OFS_YAW - HI_BASE + 1], hi_d[OFS_YAW - HI_BASE]};
	end

	// A checked frame always returns the parser to header hunting.
	a_good_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		good |=> phase_q == PH_HEADER)
		else $error("frame end did not return to header hunt");

	// The mark phase follows a header byte only.
	a_mark_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MARK |-> cnt_q == 16'd1 && sum_q == HDR_BYTE)
		else $error("mark phase without header byte");

	// The high length byte is always the fourth byte of the frame.
	a_len_hi_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEN_HI |-> cnt_q == 16'd3)
		else $error("length byte count mismatch");

	// Body bytes start at frame position four.
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> cnt_q >= 16'd4)
		else $error("body entered with short count");

endmodule

### rtl/position_frame_parser_top.sv
// ----------------------------------------------------------------------------
// position_frame_parser_top
// Byte-serial position frame parser: an input register, the frame core and a
// result register that holds an unpacked frame until it is taken.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                       Content
//  s_*       in         s_tvalid s_tready s_tdata     one received byte
//  m_*       out        m_tvalid m_tready m_tdata     unpacked good frame
//  cfg_*     in         cfg_we cfg_index cfg_data     function mark, length limit
//
//  One byte per cycle sustained while results are taken; a byte waits in the
//  input register before it reaches the frame core, and a frame result is
//  shown in the cycle after its checksum byte is processed. Control state and
//  the stored field bytes are cleared by arst_n; no clearing pass is needed.
//  When a result is not taken, at most one more byte enters before s_tready drops.
// ----------------------------------------------------------------------------
module position_frame_parser_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] remote_time_ms, [39:32] precision_max, [63:40] pos_x,
	// [87:64] pos_y, [111:88] pos_z, [135:112] vel_x, [159:136] vel_y,
	// [183:160] vel_z, [199:184] roll_cdeg, [215:200] pitch_cdeg,
	// [231:216] yaw_cdeg
	output logic [pfp_pkg::RESULT_W-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [15:0]                   cfg_data
);
	import pfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       good;
	result_t    result;
	logic       out_valid_q;
	result_t    out_q;

	// The held byte moves on when the result slot is free or being emptied.
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	pfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.data_byte (byte_s1),
		.good      (good),
		.result    (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (good) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (good) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule
